// ----- rtl/dlle_pkg.sv -----
// ----------------------------------------------------------------------------
// dlle_pkg: shared types and codes for the doubly linked list engine
// Request codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dlle_pkg;

   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_INS_HD  = 3'd1;
   localparam logic [2:0] OP_INS_POS = 3'd2;
   localparam logic [2:0] OP_SEARCH  = 3'd3;
   localparam logic [2:0] OP_POP_TL  = 3'd4;
   localparam logic [2:0] OP_POP_HD  = 3'd5;
   localparam logic [2:0] OP_REMOVE  = 3'd6;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_POS   = 3'd1;
   localparam logic [2:0] STAT_EMPTY     = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_FULL      = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TAKE,
      ST_LINK,
      ST_WALK,
      ST_MID1,
      ST_MID2,
      ST_UNLINK,
      ST_GIVE,
      ST_RESP
   } state_type;

endpackage

// ----- rtl/dlle_ram.sv -----
// ----------------------------------------------------------------------------
// dlle_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered and held when idle.
// ----------------------------------------------------------------------------
module dlle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/doubly_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// doubly_linked_list_engine: bounded doubly linked list of values in slot RAMs
// Insert at head/tail and pops need no walk; search and remove by value walk
//   from the head until a match or the last element; positional insert walks
//   to its position. The walk follows one link per cycle through the read port.
// Throughput: one transaction at a time; start is taken the cycle after rsp_valid,
//   and the response side has no backpressure.
// Reset: synchronous; control state clears, no RAM clearing pass.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_found_position,
   output logic [6:0]         rsp_list_length
);

   localparam int SW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   dlle_pkg::state_type state_ff, state_in;

   // latched transaction
   logic [2:0]            op_ff, op_in;
   logic [6:0]            pos_ff, pos_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;

   // list bookkeeping; slots below fresh_ff have been used at least once,
   // the recycled ones sit on a stack chained through the next links
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [SW-1:0] free_ff, free_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fresh_ff, fresh_in;

   // walk and result registers
   logic [SW-1:0] new_ff, new_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] found_ff, found_in;
   logic [2:0]    status_ff, status_in;
   logic          pend_ff, pend_in;

   // RAM ports
   logic                  v_we, n_we, p_we, rd_en;
   logic [SW-1:0]         v_wa, n_wa, p_wa, rd_addr;
   logic [SW-1:0]         n_wd, p_wd;
   logic [VALUE_BITS-1:0] val_rd;
   logic [SW-1:0]         nxt_rd, prv_rd;

   logic is_full, stack_empty, is_empty, pos_bad, pos_zero, pos_at_end;
   logic val_hit, walk_last, pos_hit, is_insert, at_head, at_tail;

   dlle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(val_ff),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(val_rd)
   );

   dlle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_nxt_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(nxt_rd)
   );

   dlle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prv_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(prv_rd)
   );

   // shared compare unit: one value compare and a few index compares
   assign is_full     = (count_ff == CW'(CAPACITY));
   assign is_empty    = (count_ff == '0);
   assign stack_empty = (fresh_ff == count_ff);
   assign pos_bad     = (CMPW'(pos_ff) > CMPW'(count_ff));
   assign pos_zero    = (pos_ff == '0);
   assign pos_at_end  = (CMPW'(pos_ff) == CMPW'(count_ff));
   assign val_hit     = (val_rd == val_ff);
   assign walk_last   = ((CMPW'(idx_ff) + CMPW'(1)) == CMPW'(count_ff));
   assign pos_hit     = ((CMPW'(idx_ff) + CMPW'(1)) == CMPW'(pos_ff));
   assign is_insert   = (op_ff == dlle_pkg::OP_APPEND) || (op_ff == dlle_pkg::OP_INS_HD) ||
                        (op_ff == dlle_pkg::OP_INS_POS);
   assign at_head     = (op_ff == dlle_pkg::OP_INS_HD) ||
                        ((op_ff == dlle_pkg::OP_INS_POS) && pos_zero);
   assign at_tail     = (op_ff == dlle_pkg::OP_APPEND) || pos_at_end;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlle_pkg::ST_IDLE: begin
            if (start) state_in = dlle_pkg::ST_DISPATCH;
         end
         dlle_pkg::ST_DISPATCH: begin
            case (op_ff)
               dlle_pkg::OP_APPEND, dlle_pkg::OP_INS_HD, dlle_pkg::OP_INS_POS: begin
                  if (is_full || ((op_ff == dlle_pkg::OP_INS_POS) && pos_bad))
                     state_in = dlle_pkg::ST_RESP;
                  else if (stack_empty)
                     state_in = dlle_pkg::ST_LINK;
                  else
                     state_in = dlle_pkg::ST_TAKE;
               end
               dlle_pkg::OP_SEARCH, dlle_pkg::OP_REMOVE: begin
                  state_in = is_empty ? dlle_pkg::ST_RESP : dlle_pkg::ST_WALK;
               end
               dlle_pkg::OP_POP_TL, dlle_pkg::OP_POP_HD: begin
                  state_in = is_empty ? dlle_pkg::ST_RESP : dlle_pkg::ST_UNLINK;
               end
               default: state_in = dlle_pkg::ST_RESP;
            endcase
         end
         dlle_pkg::ST_TAKE: state_in = dlle_pkg::ST_LINK;
         dlle_pkg::ST_LINK: begin
            if (is_empty || at_head || at_tail) state_in = dlle_pkg::ST_RESP;
            else state_in = dlle_pkg::ST_WALK;
         end
         dlle_pkg::ST_WALK: begin
            if (pend_ff) begin
               if (is_insert) begin
                  if (pos_hit) state_in = dlle_pkg::ST_MID1;
               end else if (val_hit) begin
                  state_in = (op_ff == dlle_pkg::OP_REMOVE) ? dlle_pkg::ST_UNLINK :
                                                               dlle_pkg::ST_RESP;
               end else if (walk_last) begin
                  state_in = dlle_pkg::ST_RESP;
               end
            end
         end
         dlle_pkg::ST_MID1:   state_in = dlle_pkg::ST_MID2;
         dlle_pkg::ST_MID2:   state_in = dlle_pkg::ST_RESP;
         dlle_pkg::ST_UNLINK: state_in = dlle_pkg::ST_GIVE;
         dlle_pkg::ST_GIVE:   state_in = dlle_pkg::ST_RESP;
         dlle_pkg::ST_RESP:   state_in = dlle_pkg::ST_IDLE;
         default:             state_in = dlle_pkg::ST_IDLE;
      endcase
   end

   // ---------------- datapath and RAM control ----------------
   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      fresh_in  = fresh_ff;
      new_in    = new_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      status_in = status_ff;
      pend_in   = pend_ff;
      v_we      = 1'b0;
      v_wa      = new_ff;
      n_we      = 1'b0;
      n_wa      = cur_ff;
      n_wd      = new_ff;
      p_we      = 1'b0;
      p_wa      = new_ff;
      p_wd      = cur_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;

      case (state_ff)
         dlle_pkg::ST_IDLE: begin
            if (start) begin
               op_in  = req_type;
               pos_in = req_position;
               val_in = VALUE_BITS'($unsigned(req_value));
            end
         end
         dlle_pkg::ST_DISPATCH: begin
            status_in = dlle_pkg::STAT_OK;
            found_in  = '0;
            pend_in   = 1'b0;
            case (op_ff)
               dlle_pkg::OP_APPEND, dlle_pkg::OP_INS_HD, dlle_pkg::OP_INS_POS: begin
                  if (is_full) begin
                     status_in = dlle_pkg::STAT_FULL;
                  end else if ((op_ff == dlle_pkg::OP_INS_POS) && pos_bad) begin
                     status_in = dlle_pkg::STAT_BAD_POS;
                  end else begin
                     v_we = 1'b1;
                     if (stack_empty) begin
                        v_wa     = fresh_ff[SW-1:0];
                        fresh_in = fresh_ff + CW'(1);
                     end else begin
                        v_wa    = free_ff;
                        rd_en   = 1'b1;
                        rd_addr = free_ff;
                     end
                     new_in = v_wa;
                  end
               end
               dlle_pkg::OP_SEARCH, dlle_pkg::OP_REMOVE: begin
                  if (is_empty)
                     status_in = (op_ff == dlle_pkg::OP_REMOVE) ? dlle_pkg::STAT_EMPTY :
                                                                   dlle_pkg::STAT_NOT_FOUND;
               end
               dlle_pkg::OP_POP_TL, dlle_pkg::OP_POP_HD: begin
                  if (is_empty) begin
                     status_in = dlle_pkg::STAT_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = (op_ff == dlle_pkg::OP_POP_TL) ? tail_ff : head_ff;
                     cur_in  = rd_addr;
                  end
               end
               default: begin
               end
            endcase
         end
         dlle_pkg::ST_TAKE: begin
            free_in = nxt_rd;
         end
         dlle_pkg::ST_LINK: begin
            if (is_empty) begin
               head_in  = new_ff;
               tail_in  = new_ff;
               count_in = count_ff + CW'(1);
            end else if (at_head) begin
               n_we     = 1'b1;
               n_wa     = new_ff;
               n_wd     = head_ff;
               p_we     = 1'b1;
               p_wa     = head_ff;
               p_wd     = new_ff;
               head_in  = new_ff;
               count_in = count_ff + CW'(1);
            end else if (at_tail) begin
               n_we     = 1'b1;
               n_wa     = tail_ff;
               n_wd     = new_ff;
               p_we     = 1'b1;
               p_wa     = new_ff;
               p_wd     = tail_ff;
               tail_in  = new_ff;
               count_in = count_ff + CW'(1);
            end
         end
         dlle_pkg::ST_WALK: begin
            if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = head_ff;
               cur_in  = head_ff;
               idx_in  = '0;
               pend_in = 1'b1;
            end else if ((is_insert && !pos_hit) ||
                         (!is_insert && !val_hit && !walk_last)) begin
               rd_en   = 1'b1;
               rd_addr = nxt_rd;
               cur_in  = nxt_rd;
               idx_in  = idx_ff + SW'(1);
            end else if (!is_insert) begin
               if (!val_hit)
                  status_in = dlle_pkg::STAT_NOT_FOUND;
               else if (op_ff == dlle_pkg::OP_SEARCH)
                  found_in = idx_ff;
            end
         end
         dlle_pkg::ST_MID1: begin
            // new slot points forward to the successor of the walk node
            n_we = 1'b1;
            n_wa = new_ff;
            n_wd = nxt_rd;
            p_we = 1'b1;
            p_wa = nxt_rd;
            p_wd = new_ff;
         end
         dlle_pkg::ST_MID2: begin
            n_we     = 1'b1;
            n_wa     = cur_ff;
            n_wd     = new_ff;
            p_we     = 1'b1;
            p_wa     = new_ff;
            p_wd     = cur_ff;
            count_in = count_ff + CW'(1);
         end
         dlle_pkg::ST_UNLINK: begin
            if (cur_ff != head_ff) begin
               n_we = 1'b1;
               n_wa = prv_rd;
               n_wd = nxt_rd;
            end else begin
               head_in = nxt_rd;
            end
            if (cur_ff != tail_ff) begin
               p_we = 1'b1;
               p_wa = nxt_rd;
               p_wd = prv_rd;
            end else begin
               tail_in = prv_rd;
            end
         end
         dlle_pkg::ST_GIVE: begin
            n_we     = 1'b1;
            n_wa     = cur_ff;
            n_wd     = free_ff;
            free_in  = cur_ff;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         dlle_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlle_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      new_ff    <= new_in;
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   // response strobe: one cycle, receiver cannot stall
   assign busy               = (state_ff != dlle_pkg::ST_IDLE);
   assign rsp_valid          = (state_ff == dlle_pkg::ST_RESP);
   assign rsp_status         = status_ff;
   assign rsp_found_position = 6'(found_ff);
   assign rsp_list_length    = 7'(count_ff);

   // ---------------- assertions ----------------
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("engine still busy after response");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transaction accepted but not busy");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("element count beyond capacity");

   a_fresh_cover: assert property (@(posedge clock) disable iff (reset)
      fresh_ff >= count_ff) else $error("more elements than slots ever used");

endmodule
